### hw/rtl/keyword_occurrence_counter_defines.svh
// Assertion macros shared by the keyword occurrence counter RTL.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH
`define KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/koc_pkg.sv
// Package for the keyword occurrence counter: request types, command codes,
// delimiter characters and default sizes. No dependencies.
package koc_pkg;

  localparam int unsigned NumKeywordsDef = 16;
  localparam int unsigned MaxWordLenDef  = 16;
  localparam int unsigned CountWidthDef  = 32;

  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_PERIOD = 8'd46;
  localparam logic [7:0] CHAR_LF     = 8'd10;

  typedef enum logic [1:0] {
    CMD_TEXT       = 2'd0,
    CMD_WRITE_CHAR = 2'd1,
    CMD_SET_LEN    = 2'd2,
    CMD_READ       = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] text_char;
    logic [3:0] slot;
    logic [3:0] char_position;
    logic [4:0] keyword_length;
  } in_req_t;

  typedef struct packed {
    logic [31:0] count;
    logic        word_matched;
    logic [3:0]  matched_slot;
    logic        word_too_long;
  } out_req_t;

  // Per-cycle controls broadcast from the top level to every slot.
  typedef struct packed {
    logic       char_step;
    logic       word_clear;
    logic       kw_write;
    logic       len_write;
    logic [7:0] ch;
  } slot_ctrl_t;

  function automatic logic is_delim(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_PERIOD) || (c == CHAR_LF);
  endfunction

endpackage

### hw/rtl/koc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module koc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/koc_slot.sv
// One keyword slot: keyword byte RAM, length, still-matching flag and count.
// Depends on koc_pkg and koc_ram.
module koc_slot #(
  parameter int unsigned MaxWordLen = koc_pkg::MaxWordLenDef,
  parameter int unsigned CountWidth = koc_pkg::CountWidthDef,
  localparam int unsigned AW = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1,
  localparam int unsigned LW = $clog2(MaxWordLen + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  koc_pkg::slot_ctrl_t    ctrl_i,
  input  logic                   sel_i,
  input  logic                   incr_i,
  input  logic [AW-1:0]          raddr_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [LW-1:0]          new_len_i,
  input  logic [LW-1:0]          cur_len_i,
  output logic                   hit_o,
  output logic [CountWidth-1:0]  count_o
);

  logic                  we;
  logic [7:0]            rdata;
  logic [7:0]            kchar;
  logic                  byp_d, byp_q;
  logic [7:0]            byp_data_q;
  logic                  match_d, match_q;
  logic [LW-1:0]         len_d, len_q;
  logic [CountWidth-1:0] cnt_d, cnt_q;

  assign we = ctrl_i.kw_write & sel_i;

  koc_ram #(
    .Width(8),
    .Depth(MaxWordLen)
  ) u_chars (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr_i),
    .wdata_i(ctrl_i.ch),
    .raddr_i(raddr_i),
    .rdata_o(rdata)
  );

  // A write landing on the address being prefetched is forwarded.
  assign byp_d = we && (waddr_i == raddr_i);
  assign kchar = byp_q ? byp_data_q : rdata;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.word_clear) begin
      match_d = 1'b1;
    end else if (ctrl_i.char_step && (kchar != ctrl_i.ch)) begin
      match_d = 1'b0;
    end
  end

  always_comb begin
    len_d = len_q;
    cnt_d = cnt_q;
    if (ctrl_i.len_write && sel_i) begin
      len_d = new_len_i;
      cnt_d = '0;
    end else if (incr_i && (cnt_q != {CountWidth{1'b1}})) begin
      cnt_d = cnt_q + CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q   <= 1'b0;
      match_q <= 1'b1;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      byp_q   <= byp_d;
      match_q <= match_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ctrl_i.ch;
  end

  assign hit_o   = (len_q != '0) && (len_q == cur_len_i) && match_q;
  assign count_o = cnt_q;

endmodule

### hw/rtl/keyword_occurrence_counter.sv
// Top level of the keyword occurrence counter.
// Depends on koc_pkg, koc_slot, koc_ram and keyword_occurrence_counter_defines.svh.
//
// Usage: requests enter on in_req_i with in_valid_i/in_ready_o and each one
// produces exactly one result on out_req_o with out_valid_o/out_ready_i.
// A request is a text byte, a keyword byte write, a keyword length write
// (which also clears that slot's count) or a count read. Text bytes build
// words that end on space, period or line end; a finished word bumps the
// saturating count of the lowest slot whose keyword equals it.
//
// Throughput is one request per cycle while the receiver keeps up: an input
// register feeds one stage of logic that compares the byte against all slots
// in parallel, and the result is captured in an output register, which
// raises out_valid_o. Each slot's keyword RAM is read ahead at the next word
// position, so its registered data is ready for the next text byte.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more request; after that in_ready_o drops.
// Reset clears lengths (all slots unused), counts, the word in progress and
// both registers' valid flags. Keyword bytes are not cleared and must be
// written before a slot is given a length; there is no clearing pass.
module keyword_occurrence_counter #(
  parameter int unsigned NumKeywords = koc_pkg::NumKeywordsDef,
  parameter int unsigned MaxWordLen  = koc_pkg::MaxWordLenDef,
  parameter int unsigned CountWidth  = koc_pkg::CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  koc_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output koc_pkg::out_req_t out_req_o
);

`include "keyword_occurrence_counter_defines.svh"

  localparam int unsigned AW   = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int unsigned LW   = $clog2(MaxWordLen + 1);
  localparam int unsigned SW   = (NumKeywords > 1) ? $clog2(NumKeywords) : 1;
  localparam int unsigned CmpW = 8;

  // Input register.
  logic             in_valid_q;
  koc_pkg::in_req_t in_q;
  // Output register.
  logic              out_valid_q;
  koc_pkg::out_req_t out_q, out_d;
  // Word in progress.
  logic [LW-1:0] cur_len_d, cur_len_q;
  logic          ovf_d, ovf_q;

  logic fire;
  logic is_text, delim, slot_ok, pos_ok;
  logic word_end, end_eval, end_long, at_limit;
  logic [LW-1:0] new_len;
  logic [AW-1:0] raddr, waddr;
  koc_pkg::slot_ctrl_t ctrl;

  logic [NumKeywords-1:0] hit, first_hit, sel;
  logic [CountWidth-1:0]  counts [NumKeywords];
  logic [CountWidth-1:0]  cnt_sel;
  logic [SW-1:0]          hit_idx;
  logic                   res_mixed;

  // The stored request is processed whenever the output register is free
  // or is being emptied in this cycle.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_len_q   <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      cur_len_q <= cur_len_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  // Decode of the stored request.
  assign is_text  = (in_q.command == koc_pkg::CMD_TEXT);
  assign delim    = koc_pkg::is_delim(in_q.text_char);
  assign slot_ok  = CmpW'(in_q.slot) < CmpW'(NumKeywords);
  assign pos_ok   = CmpW'(in_q.char_position) < CmpW'(MaxWordLen);
  assign at_limit = CmpW'(cur_len_q) >= CmpW'(MaxWordLen);
  assign word_end = fire && is_text && delim && (cur_len_q != '0);
  assign end_eval = word_end && !ovf_q;
  assign end_long = word_end && ovf_q;

  // Lengths beyond the maximum saturate.
  assign new_len = (CmpW'(in_q.keyword_length) > CmpW'(MaxWordLen)) ?
                   LW'(MaxWordLen) : LW'(in_q.keyword_length);

  always_comb begin
    cur_len_d = cur_len_q;
    ovf_d     = ovf_q;
    if (fire && is_text) begin
      if (delim) begin
        cur_len_d = '0;
        ovf_d     = 1'b0;
      end else if (at_limit) begin
        ovf_d = 1'b1;
      end else begin
        cur_len_d = cur_len_q + LW'(1);
      end
    end
  end

  // Keyword RAMs are read at the position the next text byte will compare.
  assign raddr = AW'(cur_len_d);
  assign waddr = AW'(in_q.char_position);

  assign ctrl.char_step  = fire && is_text && !delim && !at_limit;
  assign ctrl.word_clear = fire && is_text && delim;
  assign ctrl.kw_write   = fire && (in_q.command == koc_pkg::CMD_WRITE_CHAR) && pos_ok;
  assign ctrl.len_write  = fire && (in_q.command == koc_pkg::CMD_SET_LEN);
  assign ctrl.ch         = in_q.text_char;

  for (genvar s = 0; s < NumKeywords; s++) begin : g_slot
    assign sel[s] = slot_ok && (CmpW'(in_q.slot) == CmpW'(s));

    koc_slot #(
      .MaxWordLen(MaxWordLen),
      .CountWidth(CountWidth)
    ) u_slot (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sel_i    (sel[s]),
      .incr_i   (end_eval && first_hit[s]),
      .raddr_i  (raddr),
      .waddr_i  (waddr),
      .new_len_i(new_len),
      .cur_len_i(cur_len_q),
      .hit_o    (hit[s]),
      .count_o  (counts[s])
    );
  end

  // Lowest matching slot wins when keywords are duplicated.
  assign first_hit = hit & (~hit + NumKeywords'(1));

  always_comb begin
    hit_idx = '0;
    for (int unsigned i = 0; i < NumKeywords; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | SW'(i);
      end
    end
  end

  assign cnt_sel = counts[SW'(in_q.slot)];

  always_comb begin
    out_d               = '0;
    out_d.word_too_long = end_long;
    if (end_eval && (hit != '0)) begin
      out_d.word_matched = 1'b1;
      out_d.matched_slot = 4'(hit_idx);
    end
    if ((in_q.command == koc_pkg::CMD_READ) && slot_ok) begin
      out_d.count = 32'(cnt_sel);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A matching result carries no count and no over-long flag.
  assign res_mixed = (out_req_o.count != '0) || out_req_o.word_too_long;

  `KOC_ASSERT_NEXT(a_word_restart, ctrl.word_clear, (cur_len_q == '0) && !ovf_q, "no restart")
  `KOC_ASSERT_NOW(a_ovf_at_limit, ovf_q, CmpW'(cur_len_q) == CmpW'(MaxWordLen), "early overflow")
  `KOC_ASSERT_NOW(a_single_winner, 1'b1, $onehot0(first_hit), "more than one slot counted")
  `KOC_ASSERT_NOW(a_result_exclusive, out_valid_o && out_req_o.word_matched, !res_mixed, "mixed")

endmodule

### test/keyword_occurrence_counter_tb.sv
// Testbench for the keyword occurrence counter: a scoreboard predicts every result
// from the accepted requests and checks them as they leave the block.
// Depends on koc_pkg and the keyword_occurrence_counter RTL only.
`timescale 1ns / 1ps

module keyword_occurrence_counter_tb;

  localparam int NumKw         = koc_pkg::NumKeywordsDef;
  localparam int MaxLen        = koc_pkg::MaxWordLenDef;
  localparam int CountW        = koc_pkg::CountWidthDef;
  localparam int RandomItems   = 110;
  localparam int HoldAfter     = 300;   // results seen before the long receiver hold-off
  localparam int HoldCycles    = 60;
  localparam int WatchdogLimit = 1000;
  localparam logic [7:0] LetterA = 8'h61;

  // The scoreboard keeps its own copy of the keyword store, lengths, counts and
  // the word in progress. Each accepted request is run through that copy and
  // the result it must cause is queued; results leaving the block are checked
  // in order against that queue.
  class koc_scoreboard;
    logic [7:0]        kw_bytes [NumKw][MaxLen];
    logic [4:0]        kw_len   [NumKw];
    logic [CountW-1:0] hit_count [NumKw];
    bit [NumKw-1:0]    still_match;
    int unsigned       word_len;
    bit                word_long;
    koc_pkg::out_req_t awaited_results [$];
    int unsigned       n_results, errors, n_matched, n_long, n_reads;

    function new();
      foreach (kw_len[s]) begin
        kw_len[s]    = '0;
        hit_count[s] = '0;
      end
      still_match = '1;
      word_len    = 0;
      word_long   = 1'b0;
    endfunction

    static function bit ends_word(logic [7:0] c);
      return (c == koc_pkg::CHAR_SPACE) || (c == koc_pkg::CHAR_PERIOD) ||
             (c == koc_pkg::CHAR_LF);
    endfunction

    function void note_request(koc_pkg::in_req_t r);
      koc_pkg::out_req_t e;
      e = '0;
      case (r.command)
        koc_pkg::CMD_TEXT: begin
          if (ends_word(r.text_char)) begin
            // An empty word is ignored; an over-long word never matches.
            if (word_len != 0) begin
              if (word_long) begin
                e.word_too_long = 1'b1;
              end else begin
                for (int s = 0; s < NumKw; s++) begin
                  if (kw_len[s] != 0 && kw_len[s] == word_len && still_match[s]) begin
                    e.word_matched = 1'b1;
                    e.matched_slot = 4'(s);
                    if (hit_count[s] != '1) hit_count[s]++;
                    break;
                  end
                end
              end
            end
            still_match = '1;
            word_len    = 0;
            word_long   = 1'b0;
          end else if (word_len >= MaxLen) begin
            word_long = 1'b1;
          end else begin
            for (int s = 0; s < NumKw; s++) begin
              if (kw_bytes[s][word_len] !== r.text_char) still_match[s] = 1'b0;
            end
            word_len++;
          end
        end
        koc_pkg::CMD_WRITE_CHAR: begin
          if (r.slot < NumKw && r.char_position < MaxLen)
            kw_bytes[r.slot][r.char_position] = r.text_char;
        end
        koc_pkg::CMD_SET_LEN: begin
          if (r.slot < NumKw) begin
            kw_len[r.slot]    = (r.keyword_length > MaxLen) ? 5'(MaxLen) : r.keyword_length;
            hit_count[r.slot] = '0;
          end
        end
        default: begin
          if (r.slot < NumKw) e.count = 32'(hit_count[r.slot]);
          n_reads++;
        end
      endcase
      n_matched += e.word_matched;
      n_long    += e.word_too_long;
      awaited_results = {awaited_results, e};
    endfunction

    function void check_result(koc_pkg::out_req_t got);
      koc_pkg::out_req_t e;
      n_results++;
      if (awaited_results.size() == 0) begin
        $error("result arrived with no request waiting for one");
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      if (got.count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, got.count);
        errors++;
      end
      if (got.word_matched !== e.word_matched) begin
        $error("word_matched: expected %0b, got %0b", e.word_matched, got.word_matched);
        errors++;
      end
      if (got.matched_slot !== e.matched_slot) begin
        $error("matched_slot: expected %0d, got %0d", e.matched_slot, got.matched_slot);
        errors++;
      end
      if (got.word_too_long !== e.word_too_long) begin
        $error("word_too_long: expected %0b, got %0b", e.word_too_long, got.word_too_long);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  koc_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  koc_pkg::out_req_t out_req_o;

  koc_scoreboard sb = new();

  // The stimulus side keeps its own view of the loaded keywords so that it can
  // spell words that should hit. It is updated when a request is accepted.
  logic [7:0] gen_bytes [NumKw][MaxLen];
  int         gen_len   [NumKw];
  int         issued;
  bit         no_idle;
  bit         hold_done;
  int         stuck_cycles;

  keyword_occurrence_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle lengths shared by both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 2))
      0:       return koc_pkg::CHAR_SPACE;
      1:       return koc_pkg::CHAR_PERIOD;
      default: return koc_pkg::CHAR_LF;
    endcase
  endfunction

  // Word bytes come mostly from a three-letter alphabet so that random words
  // and keywords collide now and then; the rest is any non-delimiter byte.
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] c;
    if ($urandom_range(0, 4) != 0) return LetterA + 8'($urandom_range(0, 2));
    do c = 8'($urandom); while (koc_scoreboard::ends_word(c));
    return c;
  endfunction

  // Every field random; the request builders below override what matters, so
  // fields a command ignores still toggle.
  function automatic koc_pkg::in_req_t noise_req();
    koc_pkg::in_req_t r;
    r.command        = koc_pkg::cmd_e'(2'($urandom));
    r.text_char      = 8'($urandom);
    r.slot           = 4'($urandom);
    r.char_position  = 4'($urandom);
    r.keyword_length = 5'($urandom);
    return r;
  endfunction

  function automatic koc_pkg::in_req_t text_req(logic [7:0] c);
    koc_pkg::in_req_t r;
    r           = noise_req();
    r.command   = koc_pkg::CMD_TEXT;
    r.text_char = c;
    return r;
  endfunction

  function automatic koc_pkg::in_req_t write_req(int s, int p, logic [7:0] c);
    koc_pkg::in_req_t r;
    r               = noise_req();
    r.command       = koc_pkg::CMD_WRITE_CHAR;
    r.slot          = 4'(s);
    r.char_position = 4'(p);
    r.text_char     = c;
    return r;
  endfunction

  function automatic koc_pkg::in_req_t len_req(int s, int n);
    koc_pkg::in_req_t r;
    r                = noise_req();
    r.command        = koc_pkg::CMD_SET_LEN;
    r.slot           = 4'(s);
    r.keyword_length = 5'(n);
    return r;
  endfunction

  function automatic koc_pkg::in_req_t read_req(int s);
    koc_pkg::in_req_t r;
    r         = noise_req();
    r.command = koc_pkg::CMD_READ;
    r.slot    = 4'(s);
    return r;
  endfunction

  // Offers one request after an optional gap and holds it until accepted.
  task automatic issue(koc_pkg::in_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    issued++;
    if (r.command == koc_pkg::CMD_WRITE_CHAR)
      gen_bytes[r.slot][r.char_position] = r.text_char;
    if (r.command == koc_pkg::CMD_SET_LEN)
      gen_len[r.slot] = (r.keyword_length > MaxLen) ? MaxLen : int'(r.keyword_length);
  endtask

  function automatic int pick_loaded_slot();
    int s;
    for (int tries = 0; tries < 16; tries++) begin
      s = $urandom_range(0, NumKw - 1);
      if (gen_len[s] != 0) return s;
    end
    return s;
  endfunction

  // Spells the keyword held in a slot and ends the word. Mode 1 flips one
  // byte, mode 2 appends one byte, so the word should miss that slot. Now and
  // then a keyword write or a count read slips in while the word is open.
  task automatic send_keyword(int s, int mode);
    int         n;
    int         bad;
    logic [7:0] c;
    n   = gen_len[s];
    bad = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) != 0)
          issue(write_req($urandom_range(0, NumKw - 1), $urandom_range(0, MaxLen - 1),
                          pick_text_byte()));
        else
          issue(read_req($urandom_range(0, NumKw - 1)));
      end
      c = gen_bytes[s][i];
      if (mode == 1 && i == bad) c = c ^ 8'h01;
      issue(text_req(c));
    end
    if (mode == 2) issue(text_req(pick_text_byte()));
    issue(text_req(pick_delim()));
  endtask

  task automatic send_text_word(int n);
    for (int i = 0; i < n; i++) issue(text_req(pick_text_byte()));
    issue(text_req(pick_delim()));
    // A second delimiter makes an empty word.
    if ($urandom_range(0, 5) == 0) issue(text_req(pick_delim()));
  endtask

  // Loads a new keyword: some of its bytes are rewritten, then the length is
  // set, which also clears the count. Lengths past the maximum saturate.
  task automatic define_keyword(int s);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 60)      n = $urandom_range(1, 5);
    else if (r < 70) n = MaxLen;
    else if (r < 80) n = $urandom_range(MaxLen + 1, 31);
    else if (r < 90) n = 0;
    else             n = $urandom_range(6, MaxLen - 1);
    for (int i = 0; i < n && i < MaxLen; i++) begin
      if ($urandom_range(0, 9) < 7) issue(write_req(s, i, LetterA + 8'($urandom_range(0, 2))));
    end
    issue(len_req(s, n));
  endtask

  // End of the no-idle stretch in the random part.
  function automatic bit issue_window_end(int base);
    return (issued - base) < 80;
  endfunction

  // Results and requests are both taken from the values present just before
  // the edge, so the order of processes within the time step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_req_o);
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
    end
  end

  // The run is stopped if neither side moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WatchdogLimit) begin
      $display("Watchdog: no request moved for %0d cycles", WatchdogLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off once enough results have
  // gone by, while the sender keeps offering so that the block backs up.
  initial begin : receiver
    int gap;
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      if (!hold_done && sb.n_results >= HoldAfter) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int base;
    int r;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_ready_i  = 1'b0;
    rst_ni       = 1'b0;
    issued       = 0;
    no_idle      = 1'b0;
    hold_done    = 1'b0;
    stuck_cycles = 0;
    foreach (gen_len[s]) gen_len[s] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every keyword byte is written once before any slot gets a length, so
    // no compare ever sees a byte that was never loaded.
    for (int s = 0; s < NumKw; s++)
      for (int p = 0; p < MaxLen; p++)
        issue(write_req(s, p, LetterA + 8'($urandom_range(0, 2))));

    // Directed part. Reset state: nothing loaded, so a word matches nothing
    // and every count reads zero.
    issue(read_req(5));
    issue(text_req(LetterA));
    issue(text_req(LetterA + 8'd1));
    issue(text_req(koc_pkg::CHAR_SPACE));
    // The same keyword in the lowest and the highest slot: only slot 0 counts.
    issue(write_req(0, 0, LetterA));
    issue(write_req(0, 1, LetterA + 8'd1));
    issue(len_req(0, 2));
    issue(write_req(NumKw - 1, 0, LetterA));
    issue(write_req(NumKw - 1, 1, LetterA + 8'd1));
    issue(len_req(NumKw - 1, 2));
    issue(text_req(LetterA));
    issue(text_req(LetterA + 8'd1));
    issue(text_req(koc_pkg::CHAR_LF));
    // Delimiters with no word in progress are ignored.
    issue(text_req(koc_pkg::CHAR_PERIOD));
    issue(text_req(koc_pkg::CHAR_SPACE));
    issue(read_req(0));
    issue(read_req(NumKw - 1));
    // Extreme byte values inside a word.
    issue(text_req(8'h00));
    issue(text_req(8'hFF));
    issue(text_req(koc_pkg::CHAR_PERIOD));
    // A length beyond the maximum saturates; the largest field value is used.
    issue(len_req(3, 31));
    issue(read_req(3));
    // Length zero frees the slot and clears its count.
    issue(len_req(0, 0));
    issue(read_req(0));

    // Random part: mostly real words built from loaded keywords, with near
    // misses, random and over-long words, reloads, reads and pure noise.
    // A stretch in the middle runs with no random gaps on either side.
    base = issued;
    for (int i = 0; i < 6; i++) define_keyword($urandom_range(0, NumKw - 1));
    while (issued - base < RandomItems) begin
      no_idle = (issued - base >= 40) && (issue_window_end(base));
      r = $urandom_range(0, 99);
      if (r < 40)      send_keyword(pick_loaded_slot(), 0);
      else if (r < 55) send_keyword(pick_loaded_slot(), $urandom_range(1, 2));
      else if (r < 67) send_text_word(($urandom_range(0, 9) == 0) ? $urandom_range(15, 20)
                                                                  : $urandom_range(1, 6));
      else if (r < 77) issue(read_req($urandom_range(0, NumKw - 1)));
      else if (r < 87) define_keyword($urandom_range(0, NumKw - 1));
      else             issue(noise_req());
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // Every request gives one result; wait for all of them, then keep the clock
    // running in case the block emits something it should not.
    while (sb.n_results < issued) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d requests: %0d keyword hits, %0d over-long words, %0d count reads.",
             issued, sb.n_matched, sb.n_long, sb.n_reads);
    $display("Duplicate slots, saturated lengths, empty words and edits inside words were included.");
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
